>>> rtl/mavg_pkg.sv
package mavg_pkg;

    localparam int SAMPLE_W = 24;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/mavg_ram.sv
module mavg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mavg_div.sv
module mavg_div #(
    parameter int SUM_W = 26,
    parameter int CNT_W = 3
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]         divisor,
    output logic signed [SUM_W-1:0]  quotient,
    output mavg_pkg::div_stat_t      stat
);

    localparam int STEP_W = $clog2(SUM_W);

    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               neg_reg, neg_next;
    logic [SUM_W-1:0]   dq_reg, dq_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   dvs_reg, dvs_next;

    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               fits;
    logic               last_step;

    assign trial     = {rem_reg, dq_reg[SUM_W-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign last_step = step_reg == STEP_W'(SUM_W - 1);

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            // work on the magnitude, restore the sign at the end
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[SUM_W-1];
            dq_next   = dividend[SUM_W-1] ? -dividend : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // one quotient bit per cycle, shifted in from the right
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            dq_next   = {dq_reg[SUM_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        neg_reg <= neg_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = neg_reg ? -dq_reg : dq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last_step;

endmodule

>>> rtl/moving_average_warmup.sv
// Boxcar moving average over the last DEPTH signed 24-bit samples, with warm-up.
// Input stream: s_tdata carries the sample, s_tuser selects push (0) or clear (1).
// Output stream: one transfer per input transfer, carrying the average of the
// held samples (truncated toward zero) and the number of samples averaged.
// A push reads the oldest sample from the ring store, updates the running total,
// then a bit-serial restoring divider produces one quotient bit per cycle.
// A push then passes ST_UPDATE, ST_LOAD and ST_DIV, where the divider works through
// all SUM_W bits (SUM_W = 24 + clog2(DEPTH)), and ST_RESULT loads m_tvalid.
// A clear goes from ST_IDLE straight to ST_RESULT and answers with zeros.
// The block takes one item at a time: s_tready is high only when idle, so a
// push or a clear holds off the next item until its result has been loaded.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits; a stalled receiver holds that result, and the
// next result waits in the divider until the output register frees up.
// Reset (aresetn low, synchronous) empties the history and drops any result;
// the sample store itself is not cleared, only the fill count.
module moving_average_warmup #(
    parameter int DEPTH = 4
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [mavg_pkg::SAMPLE_W-1:0]                s_tdata,  // [23:0] sample
    input  logic                                         s_tuser,  // [0] func
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // [23:0] average, then fill_count, zero padded to whole bytes
    output logic [((mavg_pkg::SAMPLE_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int SAMPLE_W = mavg_pkg::SAMPLE_W;
    localparam int PTR_W    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(DEPTH);
    localparam int OUT_W    = ((SAMPLE_W + CNT_W + 7) / 8) * 8;

    mavg_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0]           pos_reg, pos_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    total_reg, total_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       clr_reg, clr_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]        m_avg_reg, m_avg_next;
    logic [CNT_W-1:0]           m_cnt_reg, m_cnt_next;

    logic                       accept;
    logic                       is_clear;
    logic                       full;
    logic                       ram_we;
    logic                       div_start;
    logic                       out_load;
    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic signed [SUM_W-1:0]    quotient;
    mavg_pkg::div_stat_t        div_stat;

    assign accept   = s_tvalid && s_tready;
    assign is_clear = s_tuser == mavg_pkg::FUNC_CLEAR;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign old_sample = full ? $signed(rd_data) : '0;

    mavg_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(pos_reg),
        .wdata(sample_reg),
        .raddr(pos_reg),
        .rdata(rd_data)
    );

    mavg_div #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(total_reg),
        .divisor (count_reg),
        .quotient(quotient),
        .stat    (div_stat)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mavg_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = is_clear ? mavg_pkg::ST_RESULT : mavg_pkg::ST_UPDATE;
                end
            end
            mavg_pkg::ST_UPDATE: state_next = mavg_pkg::ST_LOAD;
            mavg_pkg::ST_LOAD:   state_next = mavg_pkg::ST_DIV;
            mavg_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = mavg_pkg::ST_RESULT;
                end
            end
            mavg_pkg::ST_RESULT: begin
                if (out_load) begin
                    state_next = mavg_pkg::ST_IDLE;
                end
            end
            default: state_next = mavg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            mavg_pkg::ST_IDLE:   s_tready  = 1'b1;
            mavg_pkg::ST_UPDATE: ram_we    = 1'b1;
            mavg_pkg::ST_LOAD:   div_start = 1'b1;
            mavg_pkg::ST_DIV:    ;
            mavg_pkg::ST_RESULT: out_load  = !m_tvalid_reg || m_tready;
            default:             ;
        endcase
    end

    always_comb begin
        pos_next      = pos_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        sample_next   = sample_reg;
        clr_next      = clr_reg;
        m_avg_next    = m_avg_reg;
        m_cnt_next    = m_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (accept) begin
            sample_next = $signed(s_tdata);
            clr_next    = is_clear;
            if (is_clear) begin
                pos_next   = '0;
                count_next = '0;
                total_next = '0;
            end
        end

        if (ram_we) begin
            // drop the overwritten sample once the window is full
            total_next = total_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
            count_next = full ? count_reg : count_reg + CNT_W'(1);
            pos_next   = (pos_reg == PTR_W'(DEPTH - 1)) ? '0 : pos_reg + PTR_W'(1);
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_avg_next    = clr_reg ? '0 : quotient[SAMPLE_W-1:0];
            m_cnt_next    = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mavg_pkg::ST_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            clr_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sample_reg <= sample_next;
        m_avg_reg  <= m_avg_next;
        m_cnt_reg  <= m_cnt_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_cnt_reg, m_avg_reg});

    a_start_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above window depth");

    a_done_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |=> state_reg == mavg_pkg::ST_RESULT)
        else $error("divider finished without result hand-off");

    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("input ready while divider busy");

endmodule
